// ----- src/r64d_pkg.sv -----
// Shared types, codes and decode/CRC functions for the radix-64 armor deframer.
package r64d_pkg;

   localparam logic [23:0] CRC_INIT = 24'hb704ce;
   localparam logic [24:0] CRC_POLY = 25'h1864cfb;

   // Header layout: octets 0..2 stored CRC, 3..6 payload length.
   localparam int HDR_CRC_OCTETS = 3;
   localparam int HDR_OCTETS     = 7;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_LEN_MOD4  = 3'd1,
      ST_SHORT     = 3'd2,
      ST_CRC_BAD   = 3'd3,
      ST_LEN_FIELD = 3'd4
   } status_type;

   // One queue entry: up to three payload octets plus an optional status item.
   typedef struct packed {
      logic [2:0]      emit;
      logic [2:0][7:0] octets;
      logic            has_status;
      status_type      status;
   } job_type;

   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [5:0] s;
      s = 6'd0;
      if (c >= 8'h41 && c <= 8'h5a) begin        // A-Z
         s = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin // a-z
         s = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin // 0-9
         s = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2b) begin               // '+'
         s = 6'd62;
      end else if (c == 8'h2f) begin               // '/'
         s = 6'd63;
      end
      return s;
   endfunction

   function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
      logic [24:0] r;
      r = {1'b0, crc ^ {b, 16'h0000}};
      for (int i = 0; i < 8; i++) begin
         r = {r[23:0], 1'b0};
         if (r[24]) begin
            r = r ^ CRC_POLY;
         end
      end
      return r[23:0];
   endfunction

endpackage

// ----- src/r64d_front.sv -----
// Front end: character decode, group assembly, header capture, CRC and status.
module r64d_front import r64d_pkg::*; #(
   parameter int COUNT_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] character,
   input  logic       final_char,
   output logic       push,
   output job_type    job
);

   logic [17:0]           pend_ff, pend_in;
   logic [1:0]            phase_ff, phase_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [23:0]           crc_ff, crc_in;
   logic [23:0]           chk_ff, chk_in;
   logic [31:0]           len_ff, len_in;
   logic [31:0]           sent_ff, sent_in;

   logic [5:0]  sext;
   logic [23:0] word;
   logic [7:0]  b;
   logic [1:0]  lsel;
   status_type  status;

   always_comb begin
      pend_in  = pend_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      crc_in   = crc_ff;
      chk_in   = chk_ff;
      len_in   = len_ff;
      sent_in  = sent_ff;
      job      = '0;
      status   = ST_OK;
      word     = '0;
      b        = '0;
      lsel     = '0;
      sext     = sextet_of(character);

      if (phase_ff != 2'd3) begin
         pend_in  = {pend_ff[11:0], sext};
         phase_in = phase_ff + 2'd1;
      end else begin
         word     = {pend_ff, sext};
         pend_in  = '0;
         phase_in = '0;
         for (int j = 0; j < 3; j++) begin
            b = word[23-8*j -: 8];
            job.octets[j] = b;
            if (cnt_in < COUNT_BITS'(HDR_CRC_OCTETS)) begin
               chk_in[8*cnt_in[1:0] +: 8] = b;
            end else begin
               crc_in = crc_byte(crc_in, b);
               if (cnt_in < COUNT_BITS'(HDR_OCTETS)) begin
                  // octet index 3..6 maps to length byte 0..3
                  lsel = cnt_in[1:0] + 2'd1;
                  len_in[8*lsel +: 8] = b;
               end else if (sent_in < len_in) begin
                  sent_in     = sent_in + 32'd1;
                  job.emit[j] = 1'b1;
               end
            end
            if (cnt_in != '1) begin
               cnt_in = cnt_in + 1'b1;
            end
         end
      end

      if (phase_in != 2'd0) begin
         status = ST_LEN_MOD4;
      end else if (cnt_in <= COUNT_BITS'(HDR_OCTETS)) begin
         status = ST_SHORT;
      end else if (crc_in != chk_in) begin
         status = ST_CRC_BAD;
      end else if (len_in == 32'd0 || len_in >= 32'(cnt_in)) begin
         status = ST_LEN_FIELD;
      end
      job.has_status = final_char;
      job.status     = final_char ? status : ST_OK;
      push           = accept && (job.emit != 3'b000 || final_char);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && final_char)) begin
         pend_ff  <= '0;
         phase_ff <= '0;
         cnt_ff   <= '0;
         crc_ff   <= CRC_INIT;
         chk_ff   <= '0;
         len_ff   <= '0;
         sent_ff  <= '0;
      end else if (accept) begin
         pend_ff  <= pend_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         chk_ff   <= chk_in;
         len_ff   <= len_in;
         sent_ff  <= sent_in;
      end
   end

endmodule

// ----- src/r64d_fifo.sv -----
// Short job queue between front and back ends.
module r64d_fifo import r64d_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type wr_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type rd_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type        mem_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in;
   logic [PW-1:0]  rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wr_data;
      end
   end

endmodule

// ----- src/r64d_back.sv -----
// Back end: splits queued jobs into result words behind an output register.
module r64d_back import r64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  job_type    head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_octet,
   output status_type rsp_status,
   output logic       rsp_last
);

   job_type    work_ff, work_in;
   logic [3:0] mask_ff, mask_in;
   logic       work_valid_ff, work_valid_in;

   logic       out_valid_ff, out_valid_in;
   logic       out_kind_ff, out_kind_in;
   logic [7:0] out_octet_ff, out_octet_in;
   status_type out_status_ff, out_status_in;
   logic       out_last_ff, out_last_in;

   logic       advance, take;
   logic [3:0] mask_rest, mask_left;

   always_comb begin
      advance   = !out_valid_ff || rsp_ready;
      take      = work_valid_ff && advance;
      mask_rest = mask_ff & (mask_ff - 4'd1);   // drop lowest pending item

      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_octet_in  = out_octet_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      if (advance) begin
         out_valid_in  = work_valid_ff;
         out_kind_in   = 1'b0;
         out_octet_in  = 8'd0;
         out_status_in = ST_OK;
         out_last_in   = (mask_rest == 4'd0);
         if (mask_ff[0]) begin
            out_octet_in = work_ff.octets[0];
         end else if (mask_ff[1]) begin
            out_octet_in = work_ff.octets[1];
         end else if (mask_ff[2]) begin
            out_octet_in = work_ff.octets[2];
         end else begin
            out_kind_in   = 1'b1;
            out_status_in = work_ff.status;
         end
      end

      mask_left     = take ? mask_rest : mask_ff;
      work_in       = work_ff;
      mask_in       = mask_left;
      work_valid_in = work_valid_ff;
      pop           = 1'b0;
      if (!work_valid_ff || mask_left == 4'd0) begin
         if (!empty) begin
            pop           = 1'b1;
            work_in       = head;
            mask_in       = {head.has_status, head.emit};
            work_valid_in = 1'b1;
         end else begin
            work_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         mask_ff       <= '0;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
         mask_ff       <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      out_kind_ff   <= out_kind_in;
      out_octet_ff  <= out_octet_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_octet  = out_octet_ff;
   assign rsp_status = out_status_ff;
   assign rsp_last   = out_last_ff;

   a_work_nonempty: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff |-> mask_ff != 4'd0)
      else $error("held job has no pending items");

   a_status_closes_run: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff |-> out_last_ff)
      else $error("status word not marked last");

   a_payload_no_status: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_kind_ff |-> out_status_ff == ST_OK)
      else $error("payload word carries a status code");

endmodule

// ----- src/radix64_armor_deframer_crc24.sv -----
// Top level of the radix-64 armor deframer with CRC-24 check.
//
//  channel | dir | handshake             | contents
//  --------+-----+-----------------------+-----------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata=character, tlast=final_char
//  rsp     | out | rsp_tvalid/rsp_tready | tdata=octet,status; tuser=kind;
//          |     |                       | tlast=end_of_run
//
// One character is taken per cycle; decode, header capture and the 24-bit
// unrolled CRC over a full group happen in the front end in that cycle.
// The back end delivers one result word per cycle from the job queue while
// rsp_tready is high, so a character that completes a group yields up to four
// words in turn; input stalls only when the job queue is full.
// The first result word passes the job queue, work register and output register.
// Synchronous active-high reset clears the decoder state, the queue and the
// output register; after a final character the decoder returns to reset state.
module radix64_armor_deframer_crc24 import r64d_pkg::*; #(
   parameter int COUNT_BITS  = 32,   // octet counter width, 16..32
   parameter int QUEUE_DEPTH = 4     // job queue entries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] character
   input  logic        req_tlast,    // final_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] octet, [10:8] status, [15:11] zero
   output logic        rsp_tuser,    // kind: 0 payload octet, 1 status
   output logic        rsp_tlast     // end_of_run
);

   logic       accept;
   logic       push, full, pop, empty;
   job_type    job, head;
   logic [7:0] octet;
   status_type status;

   // Front stalls only on a full queue.
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   r64d_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .character  (req_tdata),
      .final_char (req_tlast),
      .push       (push),
      .job        (job)
   );

   r64d_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (job),
      .full    (full),
      .pop     (pop),
      .empty   (empty),
      .rd_data (head)
   );

   r64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_octet  (octet),
      .rsp_status (status),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'b00000, 3'(status), octet};

endmodule

// ----- dv/tb_radix64_armor_deframer_crc24.sv -----
// Self-checking testbench for the radix-64 armor deframer with CRC-24 check.

typedef struct packed {
   logic                 kind;        // 0 payload octet, 1 status
   logic [7:0]           octet;
   r64d_pkg::status_type status;
   logic                 end_of_run;
} armor_word_type;

typedef struct packed {
   logic [7:0] ch;
   logic       fin;
} armor_char_type;

// Expected-word store plus a cycle-free model of the deframer.
class armor_scoreboard;
   armor_word_type expected_words[$];
   int             mismatches;

   // decoder state, mirrors the block's per-string state
   bit [17:0]   sextet_acc;
   bit [1:0]    group_pos;
   bit [31:0]   octets_seen;
   bit [23:0]   crc_run;
   bit [23:0]   crc_stored;
   bit [31:0]   len_field;
   bit [31:0]   payload_sent;

   function new();
      mismatches = 0;
      clear_decoder();
   endfunction

   function void clear_decoder();
      sextet_acc   = '0;
      group_pos    = '0;
      octets_seen  = '0;
      crc_run      = r64d_pkg::CRC_INIT;
      crc_stored   = '0;
      len_field    = '0;
      payload_sent = '0;
   endfunction

   static function bit [5:0] sextet_value(bit [7:0] c);
      if (c >= "A" && c <= "Z") return 6'(c - "A");
      if (c >= "a" && c <= "z") return 6'(c - "a" + 26);
      if (c >= "0" && c <= "9") return 6'(c - "0" + 52);
      if (c == "+") return 6'd62;
      if (c == "/") return 6'd63;
      return 6'd0;     // padding and stray bytes
   endfunction

   // MSB-first CRC-24, one octet
   static function bit [23:0] crc_next(bit [23:0] c, bit [7:0] b);
      bit msb;
      c = c ^ {b, 16'h0000};
      for (int i = 0; i < 8; i++) begin
         msb = c[23];
         c   = c << 1;
         if (msb) c = c ^ r64d_pkg::CRC_POLY[23:0];
      end
      return c;
   endfunction

   function void push_word(bit kind, bit [7:0] oct, r64d_pkg::status_type st);
      armor_word_type w;
      w.kind       = kind;
      w.octet      = oct;
      w.status     = st;
      w.end_of_run = 1'b0;
      expected_words.push_back(w);
   endfunction

   // one accepted character: predict the words it causes
   function void note_char(bit [7:0] ch, bit fin);
      bit [23:0]            grp;
      bit [7:0]             b;
      int                   start_size;
      r64d_pkg::status_type st;
      start_size = expected_words.size();
      if (group_pos != 2'd3) begin
         sextet_acc = {sextet_acc[11:0], sextet_value(ch)};
         group_pos++;
      end else begin
         grp        = {sextet_acc, sextet_value(ch)};
         sextet_acc = '0;
         group_pos  = '0;
         for (int j = 0; j < 3; j++) begin
            b = grp[23 - 8*j -: 8];
            if (octets_seen < r64d_pkg::HDR_CRC_OCTETS) begin
               crc_stored[8*octets_seen +: 8] = b;
            end else begin
               crc_run = crc_next(crc_run, b);
               if (octets_seen < r64d_pkg::HDR_OCTETS) begin
                  len_field[8*(octets_seen - r64d_pkg::HDR_CRC_OCTETS) +: 8] = b;
               end else if (payload_sent < len_field) begin
                  payload_sent++;
                  push_word(1'b0, b, r64d_pkg::ST_OK);
               end
            end
            if (octets_seen != '1) octets_seen++;   // counter saturates
         end
      end
      if (fin) begin
         if (group_pos != 2'd0)                         st = r64d_pkg::ST_LEN_MOD4;
         else if (octets_seen <= r64d_pkg::HDR_OCTETS)  st = r64d_pkg::ST_SHORT;
         else if (crc_run != crc_stored)                st = r64d_pkg::ST_CRC_BAD;
         else if (len_field == 0 || len_field >= octets_seen) st = r64d_pkg::ST_LEN_FIELD;
         else                                           st = r64d_pkg::ST_OK;
         push_word(1'b1, 8'h00, st);
         clear_decoder();
      end
      if (expected_words.size() > start_size)
         expected_words[expected_words.size() - 1].end_of_run = 1'b1;
   endfunction

   function void check_word(logic [15:0] data, logic user, logic fin);
      armor_word_type exp_w;
      if (expected_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected word data=%04h user=%b last=%b", $time, data, user, fin);
         return;
      end
      exp_w = expected_words.pop_front();
      if (user !== exp_w.kind || data[7:0] !== exp_w.octet || data[10:8] !== exp_w.status ||
          data[15:11] !== 5'd0 || fin !== exp_w.end_of_run) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch exp kind=%b octet=%02h status=%0d last=%b, got kind=%b data=%04h last=%b",
                     $time, exp_w.kind, exp_w.octet, exp_w.status, exp_w.end_of_run,
                     user, data, fin);
      end
   endfunction
endclass

module tb_radix64_armor_deframer_crc24;
   timeunit 1ns;
   timeprecision 1ps;

   // cycles without any handshake before the run is declared hung
   localparam int HANG_LIMIT = 5000;
   // quiet cycles after the last expected word, to catch stray output
   localparam int DRAIN_CYCLES = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] character
   logic        req_tlast  = 1'b0;    // final_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] octet, [10:8] status, [15:11] zero
   logic        rsp_tuser;            // kind
   logic        rsp_tlast;            // end_of_run

   armor_scoreboard sb;
   armor_char_type  char_stream[$];   // full character sequence, built up front
   bit              no_idle = 1'b0;   // both sides run flat out while set
   int              quiet_cycles = 0;

   radix64_armor_deframer_crc24 i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sink back-pressure: stalls about 27% of cycles except in the flat-out stretch.
   always @(posedge clock) begin
      rsp_tready <= !reset && (no_idle || $urandom_range(99) >= 27);
   end

   // Monitor: both channels sampled at the edge, pre-NBA values. Input words are
   // noted before output words are checked; latency keeps them apart anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
            $display("tb_radix64_armor_deframer_crc24 failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic push_char(bit [7:0] c, bit fin);
      armor_char_type e;
      e.ch  = c;
      e.fin = fin;
      char_stream.push_back(e);
   endtask

   // Build one armored string: header (stored CRC, length field), random payload,
   // encoded four characters per three octets.
   //   tail < 0 drops characters, tail > 0 appends random bytes (breaks mod-4)
   //   scramble replaces some zero sextets with stray bytes that also decode to 0
   task automatic build_armor(int groups, bit [31:0] len, bit crc_ok, int tail,
                              bit scramble);
      bit [7:0]  oct[64];
      bit [7:0]  chars[$];
      bit [23:0] crc;
      bit [23:0] grp;
      bit [5:0]  v;
      bit [7:0]  c;
      int        n;
      n   = 3 * groups;
      crc = r64d_pkg::CRC_INIT;
      for (int i = 0; i < n; i++) oct[i] = 8'($urandom_range(255));
      for (int i = 3; i < 7 && i < n; i++) oct[i] = len[8*(i-3) +: 8];
      for (int i = 3; i < n; i++) crc = sb.crc_next(crc, oct[i]);
      if (!crc_ok) crc = crc ^ 24'($urandom_range(1, 24'hffffff));
      for (int i = 0; i < 3; i++) oct[i] = crc[8*i +: 8];
      for (int g = 0; g < groups; g++) begin
         grp = {oct[3*g], oct[3*g+1], oct[3*g+2]};
         for (int k = 0; k < 4; k++) begin
            v = grp[23 - 6*k -: 6];
            if (v < 26)       c = 8'("A" + v);
            else if (v < 52)  c = 8'("a" + v - 26);
            else if (v < 62)  c = 8'("0" + v - 52);
            else if (v == 62) c = "+";
            else              c = "/";
            if (scramble && v == 6'd0 && $urandom_range(1) == 1) begin
               do c = 8'($urandom_range(255));
               while (sb.sextet_value(c) != 6'd0 || c == "A");
            end
            chars.push_back(c);
         end
      end
      if (tail < 0) repeat (-tail) void'(chars.pop_back());
      else          repeat (tail) chars.push_back(8'($urandom_range(255)));
      foreach (chars[i]) push_char(chars[i], i == chars.size() - 1);
   endtask

   // Random strings: mostly well-formed with random content, the rest broken.
   task automatic build_random_strings(int char_goal);
      int        pick;
      int        groups;
      int        n;
      bit [31:0] len;
      while (char_stream.size() < char_goal) begin
         pick   = $urandom_range(99);
         groups = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(3, 8);
         n      = 3 * groups;
         if (pick < 55) begin
            // good string, length field anywhere in 1..count-1
            case ($urandom_range(3))
               0:       len = 32'd1;
               1:       len = n - 1;
               default: len = $urandom_range(1, n - 1);
            endcase
            build_armor(groups, len, 1'b1, 0, $urandom_range(1));
         end else if (pick < 65) begin
            build_armor(groups, $urandom_range(1, n - 1), 1'b0, 0, $urandom_range(1));
         end else if (pick < 75) begin
            // length field zero or not below the octet count
            case ($urandom_range(3))
               0:       len = 32'd0;
               1:       len = n;
               2:       len = 32'hffff_ffff;
               default: len = n + $urandom_range(1, 1000);
            endcase
            build_armor(groups, len, 1'b1, 0, $urandom_range(1));
         end else if (pick < 83) begin
            build_armor(groups, $urandom_range(1, n - 1), 1'b1,
                        $urandom_range(1) ? $urandom_range(1, 3) : -$urandom_range(1, 3),
                        $urandom_range(1));
         end else if (pick < 90) begin
            build_armor($urandom_range(1, 2), $urandom, $urandom_range(1), 0, $urandom_range(1));
         end else begin
            // raw noise, any byte values
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++) push_char(8'($urandom_range(255)), i == n - 1);
         end
      end
   endtask

   // Drive the character stream; tvalid holds until the word is taken.
   task automatic send_chars();
      int idx;
      bit holding;
      idx     = 0;
      holding = 1'b0;
      while (idx < char_stream.size() || holding) begin
         @(posedge clock);
         if (holding && req_tready) holding = 1'b0;
         if (!holding) begin
            no_idle = (idx >= 150 && idx < 260);
            if (idx < char_stream.size() && (no_idle || $urandom_range(99) >= 27)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= char_stream[idx].ch;
               req_tlast  <= char_stream[idx].fin;
               idx++;
               holding = 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      sb = new();

      // Directed strings
      // lone character: incomplete group
      push_char("/", 1'b1);
      // one group of extremes plus padding: only three octets, too short
      push_char("+", 1'b0);
      push_char("/", 1'b0);
      push_char(8'hff, 1'b0);
      push_char("=", 1'b1);
      // smallest good string, one of two payload octets emitted
      build_armor(3, 32'd1, 1'b1, 0, 1'b1);
      // zero length field with a valid CRC
      build_armor(3, 32'd0, 1'b1, 0, 1'b0);

      build_random_strings(320);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_chars();

      // wait for every expected word, then a short quiet window
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("tb_radix64_armor_deframer_crc24 passed");
      end else begin
         $display("tb_radix64_armor_deframer_crc24 failed");
      end
      $finish;
   end

endmodule
